[src/skfb_pkg.sv]
// Shared widths, register indexes, reset values and the sequencer control
// struct for the scalar Kalman filter bank. Depends on nothing.

package skfb_pkg;

    localparam int SKFB_CHANNELS = 16;

    localparam int CH_W   = 4;
    localparam int SMP_W  = 32;
    localparam int VAR_W  = 32;
    localparam int FRAC_W = 24;
    localparam int K_W    = FRAC_W + 1;
    localparam int STEP_W = $clog2(K_W);
    localparam int DIFF_W = SMP_W + 1;
    localparam int DEN_W  = VAR_W + 1;
    localparam int PD_W   = DIFF_W + K_W;
    localparam int PP_W   = VAR_W + FRAC_W;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VARIANCE     = 2'd2;

    localparam logic [CFG_W-1:0] PROCESS_NOISE_RST     = 32'd577975;
    localparam logic [CFG_W-1:0] MEASUREMENT_NOISE_RST = 32'd1174405;
    localparam logic [CFG_W-1:0] INIT_VARIANCE_RST     = 32'd167772;

    typedef struct packed {
        logic load;
        logic first;
        logic step;
        logic round;
    } skfb_ctl_t;

endpackage

[src/scalar_kalman_filter_bank.sv]
// Bank of one-dimensional Kalman filters (A = H = 1), one per channel. A filter
// update goes from the input transfer through the RAM read, the predict step, the
// load, the radix-2 gain divider whose quotient bits drive the two serial
// multiply-accumulators as they appear, rounding, the write-back and the output
// load. A restart, the first item after reset and an out-of-range channel pass
// the sample through. A restart re-seeds all channels at once through per-channel
// fresh flags; there is no clearing pass.
// The result sits in an output register, so the next item is taken while it waits.
// Write configuration only while the block is idle.
// Depends on skfb_pkg, skfb_ram, skfb_gain and skfb_update.

module scalar_kalman_filter_bank #(
    parameter int CHANNELS = skfb_pkg::SKFB_CHANNELS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wen,
    input  logic        [skfb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [skfb_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic        [skfb_pkg::CH_W-1:0]     s_channel,
    input  logic signed [skfb_pkg::SMP_W-1:0]    s_sample,
    input  logic                                 s_restart,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [skfb_pkg::SMP_W-1:0]    m_estimate
);
    import skfb_pkg::*;

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RAM_W  = SMP_W + VAR_W;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(K_W - 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_PREP  = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_ROUND = 7'b0010000,
        S_WRITE = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t                    state_reg, state_next;
    logic                      seeded_reg, seeded_next;
    logic [CHANNELS-1:0]       fresh_reg, fresh_next;
    logic [CFG_W-1:0]          process_noise_reg, process_noise_next;
    logic [CFG_W-1:0]          measurement_noise_reg, measurement_noise_next;
    logic [CFG_W-1:0]          init_variance_reg, init_variance_next;
    logic                      m_valid_reg, m_valid_next;
    logic [STEP_W-1:0]         step_reg, step_next;

    logic signed [SMP_W-1:0]   seed_est_reg, seed_est_next;
    logic        [VAR_W-1:0]   seed_var_reg, seed_var_next;
    logic        [ADDR_W-1:0]  ch_reg, ch_next;
    logic signed [SMP_W-1:0]   z_reg, z_next;
    logic signed [SMP_W-1:0]   x_reg, x_next;
    logic        [VAR_W-1:0]   p_reg, p_next;
    logic signed [SMP_W-1:0]   res_reg, res_next;
    logic signed [SMP_W-1:0]   m_estimate_reg, m_estimate_next;

    logic                      s_accept;
    logic                      reseed;
    logic                      in_range;
    logic                      out_free;
    logic [RAM_W-1:0]          ram_rdata;
    logic [RAM_W-1:0]          ram_wdata;
    logic                      ram_we;
    logic signed [SMP_W-1:0]   rd_est;
    logic        [VAR_W-1:0]   rd_var;
    logic        [VAR_W:0]     p_sum;
    logic        [VAR_W-1:0]   p_sat;
    logic                      kbit;
    logic signed [SMP_W-1:0]   x_new;
    logic        [VAR_W-1:0]   p_new;
    skfb_ctl_t                 ctl;

    assign s_ready    = (state_reg == S_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign m_valid    = m_valid_reg;
    assign m_estimate = m_estimate_reg;

    always_comb begin
        reseed    = !seeded_reg || s_restart;
        in_range  = (32'(s_channel) < 32'(CHANNELS));
        out_free  = !m_valid_reg || m_ready;
        rd_est    = fresh_reg[ch_reg] ? ram_rdata[RAM_W-1:VAR_W] : seed_est_reg;
        rd_var    = fresh_reg[ch_reg] ? ram_rdata[VAR_W-1:0] : seed_var_reg;
        p_sum     = {1'b0, rd_var} + {1'b0, process_noise_reg};
        p_sat     = p_sum[VAR_W] ? '1 : p_sum[VAR_W-1:0];
        ram_we    = (state_reg == S_WRITE);
        ram_wdata = {x_new, p_new};

        ctl.load  = (state_reg == S_PREP);
        ctl.step  = (state_reg == S_DIV);
        ctl.first = (step_reg == '0);
        ctl.round = (state_reg == S_ROUND);
    end

    always_comb begin
        state_next             = state_reg;
        seeded_next            = seeded_reg;
        fresh_next             = fresh_reg;
        process_noise_next     = process_noise_reg;
        measurement_noise_next = measurement_noise_reg;
        init_variance_next     = init_variance_reg;
        m_valid_next           = m_valid_reg;
        step_next              = step_reg;
        seed_est_next          = seed_est_reg;
        seed_var_next          = seed_var_reg;
        ch_next                = ch_reg;
        z_next                 = z_reg;
        x_next                 = x_reg;
        p_next                 = p_reg;
        res_next               = res_reg;
        m_estimate_next        = m_estimate_reg;

        if (cfg_wen) begin
            unique case (cfg_index)
                REG_PROCESS_NOISE:     process_noise_next     = cfg_wdata;
                REG_MEASUREMENT_NOISE: measurement_noise_next = cfg_wdata;
                REG_INIT_VARIANCE:     init_variance_next     = cfg_wdata;
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    ch_next  = ADDR_W'(s_channel);
                    z_next   = s_sample;
                    res_next = s_sample;
                    if (reseed) begin
                        seeded_next   = 1'b1;
                        fresh_next    = '0;
                        seed_est_next = s_sample;
                        seed_var_next = init_variance_reg;
                        state_next    = S_OUT;
                    end else if (in_range) begin
                        state_next = S_READ;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_READ: begin
                x_next     = rd_est;
                p_next     = p_sat;
                state_next = S_PREP;
            end
            S_PREP: begin
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND: begin
                state_next = S_WRITE;
            end
            S_WRITE: begin
                fresh_next[ch_reg] = 1'b1;
                res_next           = x_new;
                state_next         = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_estimate_next = res_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg             <= S_IDLE;
            seeded_reg            <= 1'b0;
            fresh_reg             <= '0;
            process_noise_reg     <= PROCESS_NOISE_RST;
            measurement_noise_reg <= MEASUREMENT_NOISE_RST;
            init_variance_reg     <= INIT_VARIANCE_RST;
            m_valid_reg           <= 1'b0;
            step_reg              <= '0;
        end else begin
            state_reg             <= state_next;
            seeded_reg            <= seeded_next;
            fresh_reg             <= fresh_next;
            process_noise_reg     <= process_noise_next;
            measurement_noise_reg <= measurement_noise_next;
            init_variance_reg     <= init_variance_next;
            m_valid_reg           <= m_valid_next;
            step_reg              <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        seed_est_reg   <= seed_est_next;
        seed_var_reg   <= seed_var_next;
        ch_reg         <= ch_next;
        z_reg          <= z_next;
        x_reg          <= x_next;
        p_reg          <= p_next;
        res_reg        <= res_next;
        m_estimate_reg <= m_estimate_next;
    end

    skfb_ram #(
        .WIDTH (RAM_W),
        .DEPTH (CHANNELS),
        .AW    (ADDR_W)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ch_reg),
        .wdata (ram_wdata),
        .re    (s_accept),
        .raddr (ADDR_W'(s_channel)),
        .rdata (ram_rdata)
    );

    skfb_gain u_gain (
        .aclk    (aclk),
        .ctl     (ctl),
        .p       (p_reg),
        .r_noise (measurement_noise_reg),
        .kbit    (kbit)
    );

    skfb_update u_update (
        .aclk  (aclk),
        .ctl   (ctl),
        .kbit  (kbit),
        .z     (z_reg),
        .x     (x_reg),
        .p     (p_reg),
        .x_new (x_new),
        .p_new (p_new)
    );

endmodule

[src/skfb_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.

module skfb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/skfb_gain.sv]
// Radix-2 restoring divider for the gain k = p * 2^24 / (p + R), one
// quotient bit per step, most significant first. Depends on skfb_pkg.

module skfb_gain (
    input  logic                         aclk,
    input  skfb_pkg::skfb_ctl_t          ctl,
    input  logic [skfb_pkg::VAR_W-1:0]   p,
    input  logic [skfb_pkg::VAR_W-1:0]   r_noise,
    output logic                         kbit
);
    import skfb_pkg::*;

    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   den_ext;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb begin
        den_ext  = {1'b0, den_reg};
        trial    = ctl.first ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        diff     = trial - den_ext;
        ge       = (trial >= den_ext);
        kbit     = ge && (den_reg != '0);
        den_next = den_reg;
        rem_next = rem_reg;
        if (ctl.load) begin
            den_next = {1'b0, p} + {1'b0, r_noise};
            rem_next = {1'b0, p};
        end else if (ctl.step) begin
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

endmodule

[src/skfb_update.sv]
// Bit-serial multiply-accumulate of the gain bits against the innovation
// and the predicted variance, then rounding and the state update.
// Depends on skfb_pkg.

module skfb_update (
    input  logic                              aclk,
    input  skfb_pkg::skfb_ctl_t               ctl,
    input  logic                              kbit,
    input  logic signed [skfb_pkg::SMP_W-1:0] z,
    input  logic signed [skfb_pkg::SMP_W-1:0] x,
    input  logic        [skfb_pkg::VAR_W-1:0] p,
    output logic signed [skfb_pkg::SMP_W-1:0] x_new,
    output logic        [skfb_pkg::VAR_W-1:0] p_new
);
    import skfb_pkg::*;

    localparam int TD_W = PD_W - FRAC_W;
    localparam logic [PD_W-1:0] HALF_D = {{(PD_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
    localparam logic [PP_W-1:0] CEIL_P = {{(PP_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}};

    logic signed [DIFF_W-1:0] d_reg, d_next;
    logic signed [PD_W-1:0]   accd_reg, accd_next;
    logic        [PP_W-1:0]   accp_reg, accp_next;
    logic signed [TD_W-1:0]   td_reg, td_next;
    logic        [VAR_W-1:0]  tp_reg, tp_next;
    logic        [PD_W-1:0]   accd_round;
    logic        [PP_W-1:0]   accp_round;
    logic        [TD_W-1:0]   x_sum;

    always_comb begin
        accd_round = accd_reg + HALF_D;
        accp_round = accp_reg + CEIL_P;
        x_sum      = {{(TD_W-SMP_W){x[SMP_W-1]}}, x} + td_reg;
        x_new      = x_sum[SMP_W-1:0];
        p_new      = p - tp_reg;

        d_next    = d_reg;
        accd_next = accd_reg;
        accp_next = accp_reg;
        td_next   = td_reg;
        tp_next   = tp_reg;
        if (ctl.load) begin
            d_next    = {z[SMP_W-1], z} - {x[SMP_W-1], x};
            accd_next = '0;
            accp_next = '0;
        end else if (ctl.step) begin
            accd_next = (accd_reg <<< 1)
                      + (kbit ? {{(PD_W-DIFF_W){d_reg[DIFF_W-1]}}, d_reg} : '0);
            accp_next = (accp_reg << 1)
                      + (kbit ? {{(PP_W-VAR_W){1'b0}}, p} : '0);
        end else if (ctl.round) begin
            td_next = accd_round[PD_W-1:FRAC_W];
            tp_next = accp_round[PP_W-1:FRAC_W];
        end
    end

    always_ff @(posedge aclk) begin
        d_reg    <= d_next;
        accd_reg <= accd_next;
        accp_reg <= accp_next;
        td_reg   <= td_next;
        tp_reg   <= tp_next;
    end

endmodule

[src/skfb_check.sv]
// Port-level checks on the scalar Kalman filter bank, bound to its top level.
// Depends on scalar_kalman_filter_bank and skfb_pkg.

module skfb_check (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic signed [skfb_pkg::SMP_W-1:0] s_sample,
    input logic                              s_restart,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [skfb_pkg::SMP_W-1:0] m_estimate
);

    // one item in flight: drop ready after each input transfer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is still in flight");

    // a restart accepted while the output is free passes its sample straight through
    a_restart_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_restart && (!m_valid || m_ready)
        |=> ##1 (m_valid && (m_estimate == $past(s_sample, 2))))
        else $error("restart result missing or not equal to its sample");

    // a new result appears only after the sequencer has left idle
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result raised without an item being processed");

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_estimate))
        else $error("stalled result dropped or changed");

endmodule

bind scalar_kalman_filter_bank skfb_check u_check (.*);
